// ===== rtl/core/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms, clocked on clk and quiet during reset
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/dhcc_pkg.sv =====
// ---------------------------------------------------------------------------
// dhcc_pkg
// types, register codes and compare helpers of the hand contour classifier
// ---------------------------------------------------------------------------
package dhcc_pkg;

    localparam int POS_W      = 10;
    localparam int DEPTH_W    = 16;
    localparam int FRAME_W    = 11;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int MAX_HEIGHT = 1024;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH     = 3'd0,
        REG_FRAME_HEIGHT    = 3'd1,
        REG_DEPTH_THRESHOLD = 3'd2,
        REG_HAND_X          = 3'd3,
        REG_HAND_Y          = 3'd4,
        REG_HAND_DEPTH      = 3'd5,
        REG_WINDOW_HALF     = 3'd6
    } cfg_reg_t;

    localparam logic [FRAME_W-1:0] RST_FRAME_WIDTH     = 11'd640;
    localparam logic [FRAME_W-1:0] RST_FRAME_HEIGHT    = 11'd480;
    localparam logic [DEPTH_W-1:0] RST_DEPTH_THRESHOLD = 16'd20;
    localparam logic [POS_W-1:0]   RST_WINDOW_HALF     = 10'd1023;

    typedef struct packed {
        logic [POS_W-1:0]   x;
        logic [POS_W-1:0]   y;
        logic [DEPTH_W-1:0] depth;
        logic               contour;
        logic               last;
        logic               fend;
    } result_t;

    function automatic logic [DEPTH_W-1:0] absdiff(logic [DEPTH_W-1:0] a,
                                                   logic [DEPTH_W-1:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

    // true when the two values lie within lim of each other
    function automatic logic near(logic [DEPTH_W-1:0] a, logic [DEPTH_W-1:0] b,
                                  logic [DEPTH_W-1:0] lim);
        return absdiff(a, b) <= lim;
    endfunction

endpackage

// ===== rtl/core/dhcc_ram.sv =====
// ---------------------------------------------------------------------------
// dhcc_ram
// simple dual-port ram, one write and one registered read port, read-first
// ---------------------------------------------------------------------------
module dhcc_ram
#(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/core/depth_hand_contour_classifier_core.sv =====
// ---------------------------------------------------------------------------
// depth_hand_contour_classifier_core
// marks depth pixels on the hand contour with a two-line store stencil
// ---------------------------------------------------------------------------
// channel  handshake            payload
// pix      pix_valid/pix_stall  depth
// res      res_valid/res_stall  pixel_x pixel_y pixel_depth is_contour
//                               last_of_run frame_end
// cfg      cfg_valid/cfg_ready  cfg_index cfg_data
//
// one pixel per cycle while pix_stall is low; the line store read issued at the
// transfer is registered with the stencil stage, which loads the result group
// registers that drive the outputs; last row pixels give up to three results,
// the result port (one per cycle while res_stall is low) then sets the pace
// async reset clears counters and pipeline valids and loads config defaults; store is not cleared
// res_stall holds the result group and, once the stencil stage is full, pix
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module depth_hand_contour_classifier_core
    import dhcc_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int DEPTH_BITS = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  pix_valid,
    output logic                  pix_stall,
    input  logic [DEPTH_W-1:0]    depth,
    output logic                  res_valid,
    input  logic                  res_stall,
    output logic [POS_W-1:0]      pixel_x,
    output logic [POS_W-1:0]      pixel_y,
    output logic [DEPTH_W-1:0]    pixel_depth,
    output logic                  is_contour,
    output logic                  last_of_run,
    output logic                  frame_end,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int XW = $clog2(MAX_WIDTH);
    localparam int CW = (XW + 1 > FRAME_W + 1) ? XW + 1 : FRAME_W + 1;
    localparam int DB = DEPTH_BITS;

    // configuration
    logic [FRAME_W-1:0] fw_reg;
    logic [FRAME_W-1:0] fh_reg;
    logic [DEPTH_W-1:0] th_reg;
    logic [POS_W-1:0]   hx_reg;
    logic [POS_W-1:0]   hy_reg;
    logic [DEPTH_W-1:0] hd_reg;
    logic [POS_W-1:0]   wh_reg;

    // input side
    logic [XW-1:0]      col_reg;
    logic [POS_W-1:0]   row_reg;
    logic [CW-1:0]      w_eff;
    logic [FRAME_W-1:0] h_eff;
    logic               acc_last_col;
    logic               acc_last_row;
    logic               pix_acc;
    logic [DB-1:0]      d_in;
    logic [XW-1:0]      col_inc;

    // stencil stage
    logic               s1_valid_reg;
    logic [XW-1:0]      s1_x_reg;
    logic [POS_W-1:0]   s1_y_reg;
    logic [DB-1:0]      s1_d_reg;
    logic               s1_lc_reg;
    logic               s1_lr_reg;
    logic [DB-1:0]      win_x_reg;
    logic [DB-1:0]      win_xm1_reg;
    logic [DB-1:0]      first_reg;
    logic [DB-1:0]      held_reg;
    logic [DB-1:0]      held2_reg;
    logic [DB-1:0]      rd0;
    logic [DB-1:0]      rd1;
    logic [DB-1:0]      rd_cur;
    logic [DB-1:0]      rd_prev;
    logic [DB-1:0]      p_x;
    logic               x_pos;
    logic               x_ge2;
    logic               y_pos;
    logic               y_ge2;
    logic               has_a;
    logic               has_b;
    logic               has_c;
    logic               s1_has;
    logic               s1_adv;
    logic               in_col_x;
    logic               in_col_xm1;
    logic               in_row_y;
    logic               in_row_ym1;
    logic [DEPTH_W-1:0] c_a;
    logic [DEPTH_W-1:0] c_b;
    logic [DEPTH_W-1:0] c_c;
    logic [DEPTH_W-1:0] n_xm1;
    logic [DEPTH_W-1:0] n_prev;
    logic [DEPTH_W-1:0] n_cur;
    logic [DEPTH_W-1:0] n_d;
    logic [DEPTH_W-1:0] n_held2;
    logic [CW-1:0]      x_ext;
    logic [CW-1:0]      xm1_ext;
    logic [POS_W-1:0]   ym1;
    result_t            res_a;
    result_t            res_b;
    result_t            res_c;

    // result group
    result_t            slot_reg [3];
    logic [2:0]         mask_reg;
    logic [2:0]         mask_next;
    logic [2:0]         lowest;
    logic               s2_free;
    logic               res_xfer;
    result_t            cur_res;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fw_reg <= RST_FRAME_WIDTH;
            fh_reg <= RST_FRAME_HEIGHT;
            th_reg <= RST_DEPTH_THRESHOLD;
            hx_reg <= '0;
            hy_reg <= '0;
            hd_reg <= '0;
            wh_reg <= RST_WINDOW_HALF;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_FRAME_WIDTH:     fw_reg <= cfg_data[FRAME_W-1:0];
                REG_FRAME_HEIGHT:    fh_reg <= cfg_data[FRAME_W-1:0];
                REG_DEPTH_THRESHOLD: th_reg <= cfg_data;
                REG_HAND_X:          hx_reg <= cfg_data[POS_W-1:0];
                REG_HAND_Y:          hy_reg <= cfg_data[POS_W-1:0];
                REG_HAND_DEPTH:      hd_reg <= cfg_data;
                REG_WINDOW_HALF:     wh_reg <= cfg_data[POS_W-1:0];
                default:             ;
            endcase
        end
    end

    // clamp geometry to the supported range
    always_comb
    begin
        if (CW'(fw_reg) < CW'(2))
            w_eff = CW'(2);
        else if (CW'(fw_reg) > CW'(MAX_WIDTH))
            w_eff = CW'(MAX_WIDTH);
        else
            w_eff = CW'(fw_reg);

        if (fh_reg < FRAME_W'(2))
            h_eff = FRAME_W'(2);
        else if (fh_reg > FRAME_W'(MAX_HEIGHT))
            h_eff = FRAME_W'(MAX_HEIGHT);
        else
            h_eff = fh_reg;
    end

    assign acc_last_col = (CW'(col_reg) + CW'(1)) >= w_eff;
    assign acc_last_row = (FRAME_W'(row_reg) + FRAME_W'(1)) >= h_eff;
    assign pix_acc      = pix_valid && !pix_stall;
    assign d_in         = depth[DB-1:0];
    assign col_inc      = col_reg + XW'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (pix_acc)
        begin
            if (acc_last_col)
            begin
                col_reg <= '0;
                row_reg <= acc_last_row ? '0 : row_reg + POS_W'(1);
            end
            else
            begin
                col_reg <= col_inc;
            end
        end
    end

    // current row bank: write pixel and read the row two above (read-first);
    // other bank: read the row above one column ahead
    dhcc_ram #(
        .WIDTH (DB),
        .DEPTH (MAX_WIDTH)
    ) u_bank0 (
        .clk   (clk),
        .we    (pix_acc && !row_reg[0]),
        .waddr (col_reg),
        .wdata (d_in),
        .re    (pix_acc),
        .raddr (row_reg[0] ? col_inc : col_reg),
        .rdata (rd0)
    );

    dhcc_ram #(
        .WIDTH (DB),
        .DEPTH (MAX_WIDTH)
    ) u_bank1 (
        .clk   (clk),
        .we    (pix_acc && row_reg[0]),
        .waddr (col_reg),
        .wdata (d_in),
        .re    (pix_acc),
        .raddr (row_reg[0] ? col_reg : col_inc),
        .rdata (rd1)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (pix_acc)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pix_acc)
        begin
            s1_x_reg  <= col_reg;
            s1_y_reg  <= row_reg;
            s1_d_reg  <= d_in;
            s1_lc_reg <= acc_last_col;
            s1_lr_reg <= acc_last_row;
        end
        if (s1_adv)
        begin
            win_xm1_reg <= p_x;
            win_x_reg   <= rd_prev;
            held2_reg   <= held_reg;
            held_reg    <= s1_d_reg;
            if (s1_x_reg == '0)
            begin
                first_reg <= s1_d_reg;
            end
        end
    end

    // stencil around the pixel of the row above, plus last-row pixels
    always_comb
    begin
        rd_cur  = s1_y_reg[0] ? rd1 : rd0;
        rd_prev = s1_y_reg[0] ? rd0 : rd1;
        p_x     = (s1_x_reg == '0) ? first_reg : win_x_reg;
        x_pos   = s1_x_reg != '0;
        x_ge2   = s1_x_reg > XW'(1);
        y_pos   = s1_y_reg != '0;
        y_ge2   = s1_y_reg > POS_W'(1);
        has_a   = y_pos;
        has_b   = y_pos && s1_lr_reg && x_pos;
        has_c   = y_pos && s1_lr_reg && s1_lc_reg;
        s1_has  = has_a || has_b || has_c;

        x_ext   = CW'(s1_x_reg);
        xm1_ext = x_ext - CW'(1);
        ym1     = s1_y_reg - POS_W'(1);

        in_col_x   = near(DEPTH_W'(x_ext), DEPTH_W'(hx_reg), DEPTH_W'(wh_reg));
        in_col_xm1 = near(DEPTH_W'(xm1_ext), DEPTH_W'(hx_reg), DEPTH_W'(wh_reg));
        in_row_y   = near(DEPTH_W'(s1_y_reg), DEPTH_W'(hy_reg), DEPTH_W'(wh_reg));
        in_row_ym1 = near(DEPTH_W'(ym1), DEPTH_W'(hy_reg), DEPTH_W'(wh_reg));

        c_a     = DEPTH_W'(p_x);
        c_b     = DEPTH_W'(held_reg);
        c_c     = DEPTH_W'(s1_d_reg);
        n_xm1   = DEPTH_W'(win_xm1_reg);
        n_prev  = DEPTH_W'(rd_prev);
        n_cur   = DEPTH_W'(rd_cur);
        n_d     = DEPTH_W'(s1_d_reg);
        n_held2 = DEPTH_W'(held2_reg);

        res_a.x       = POS_W'(s1_x_reg);
        res_a.y       = ym1;
        res_a.depth   = c_a;
        res_a.contour = in_col_x && in_row_ym1 && near(hd_reg, c_a, th_reg) &&
                        ((x_pos && !near(c_a, n_xm1, th_reg)) ||
                         (!s1_lc_reg && !near(c_a, n_prev, th_reg)) ||
                         (y_ge2 && !near(c_a, n_cur, th_reg)) ||
                         !near(c_a, n_d, th_reg));
        res_a.last    = !has_b && !has_c;
        res_a.fend    = 1'b0;

        res_b.x       = POS_W'(xm1_ext);
        res_b.y       = s1_y_reg;
        res_b.depth   = c_b;
        res_b.contour = in_col_xm1 && in_row_y && near(hd_reg, c_b, th_reg) &&
                        ((x_ge2 && !near(c_b, n_held2, th_reg)) ||
                         !near(c_b, n_d, th_reg) ||
                         !near(c_b, n_xm1, th_reg));
        res_b.last    = !has_c;
        res_b.fend    = 1'b0;

        res_c.x       = POS_W'(s1_x_reg);
        res_c.y       = s1_y_reg;
        res_c.depth   = c_c;
        res_c.contour = in_col_x && in_row_y && near(hd_reg, c_c, th_reg) &&
                        ((x_pos && !near(c_c, c_b, th_reg)) ||
                         !near(c_c, c_a, th_reg));
        res_c.last    = 1'b1;
        res_c.fend    = 1'b1;
    end

    // result group drains one per cycle while res_stall is low, lowest pending slot first
    assign res_valid = mask_reg != 3'b000;
    assign res_xfer  = res_valid && !res_stall;
    assign lowest    = mask_reg & (~mask_reg + 3'd1);
    assign s2_free   = (mask_reg == 3'b000) ||
                       (res_xfer && ((mask_reg & (mask_reg - 3'd1)) == 3'b000));
    assign s1_adv    = s1_valid_reg && (!s1_has || s2_free);
    assign pix_stall = s1_valid_reg && !s1_adv;

    always_comb
    begin
        if (s1_adv && s1_has)
            mask_next = {has_c, has_b, has_a};
        else if (res_xfer)
            mask_next = mask_reg & ~lowest;
        else
            mask_next = mask_reg;

        if (mask_reg[0])
            cur_res = slot_reg[0];
        else if (mask_reg[1])
            cur_res = slot_reg[1];
        else
            cur_res = slot_reg[2];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg <= 3'b000;
        end
        else
        begin
            mask_reg <= mask_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && s1_has)
        begin
            slot_reg[0] <= res_a;
            slot_reg[1] <= res_b;
            slot_reg[2] <= res_c;
        end
    end

    assign pixel_x     = cur_res.x;
    assign pixel_y     = cur_res.y;
    assign pixel_depth = cur_res.depth;
    assign is_contour  = cur_res.contour;
    assign last_of_run = cur_res.last;
    assign frame_end   = cur_res.fend;

    `ASSERT_NEXT(a_col_wrap, pix_acc && acc_last_col, col_reg == '0, "column did not wrap at row end")
    `ASSERT_IMPL(a_fend_last, res_valid && frame_end, last_of_run, "frame end result not last of run")
    `ASSERT_NEXT(a_run_cont, res_xfer && !last_of_run, res_valid, "result run broken before its last")
    `ASSERT_IMPL(a_no_overwrite, s1_adv && s1_has && (mask_reg != 3'b000), res_xfer, "result group overwritten")

endmodule
